// ===== src/cts_pkg.sv =====
package cts_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int TAG_W  = 16;
    localparam int MS_W   = 32;
    localparam int TICK_W = 29;
    localparam int PEND_W = 8;
    localparam int IDX_W  = 8;
    localparam int ST_W   = 3;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 4;

    // results per dispatch
    localparam int MAX_RESULTS = 8;

    // pending run saturation
    localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;

    // ms to 10 ms ticks: x / 10 == (x * 0xCCCCCCCD) >> 35 for any 32-bit x
    localparam logic [MS_W-1:0] DIV10_MAGIC = 32'hCCCCCCCD;
    localparam int              DIV10_SHIFT = 35;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_NONE_DUE = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd4;

    // command token walking down the cell chain
    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  cmd;
        logic [TAG_W-1:0]  tag;
        logic [TICK_W-1:0] delay;
        logic [TICK_W-1:0] period;
        logic [IDX_W-1:0]  idx;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  cnt;
    } t_tok;

    // dispatch hit raised by a cell
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
    } t_hit;

endpackage

// ===== src/cooperative_task_scheduler.sv =====
// cooperative task scheduler: a table of task slots driven by 10 ms ticks
//
// input channel s_axis: one transfer is one command. tuser carries the
// command (tick, dispatch, add, delete); tdata carries tag, delay and
// period in ms and the slot index. output channel m_axis: each transfer is
// one result; tlast marks the final result of a command. tick, add and
// delete give one result, dispatch gives one result per due slot (at most
// eight) or a single nothing-due result.
//
// each slot lives in a cell of a chain; a command token enters the chain
// and moves one cell per cycle unless a stalled receiver freezes it. the ms
// values are scaled to ticks by a reciprocal multiply as the token enters
// the first cell; past the last cell an end register forms the last result.
// one command is in flight at a time, so s_axis_tready drops after a
// transfer and rises again once the final result is in the output register.
//
// a stalled receiver freezes the token wherever it must hand over a result;
// the output register holds its result until taken. reset empties all
// slots and clears the sticky error mark.
module cooperative_task_scheduler #(
    parameter int TASK_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tag[15:0], delay_ms[47:16], period_ms[79:48], slot_index[87:80]
    input  logic [87:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], slot_number[6:3], run_tag[22:7], error_flag[23]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam logic [cts_pkg::SLOT_W-1:0] FULL_SLOT  = cts_pkg::SLOT_W'(TASK_SLOTS);
    localparam logic [cts_pkg::IDX_W-1:0]  SLOT_LIMIT = cts_pkg::IDX_W'(TASK_SLOTS);

    logic accept;
    logic go;
    logic out_free;
    logic out_load;
    logic end_done;

    logic                       r_busy;
    logic                       r_in_v;
    logic [cts_pkg::CMD_W-1:0]  r_in_cmd;
    logic [cts_pkg::TAG_W-1:0]  r_in_tag;
    logic [cts_pkg::MS_W-1:0]   r_in_delay;
    logic [cts_pkg::MS_W-1:0]   r_in_period;
    logic [cts_pkg::IDX_W-1:0]  r_in_idx;

    logic [2*cts_pkg::MS_W-1:0] prod_delay;
    logic [2*cts_pkg::MS_W-1:0] prod_period;

    cts_pkg::t_tok tok_link [0:TASK_SLOTS];
    cts_pkg::t_hit hits     [0:TASK_SLOTS-1];
    cts_pkg::t_hit hit_or;
    cts_pkg::t_tok r_end;

    logic                       r_hold_v,   n_hold_v;
    logic [cts_pkg::SLOT_W-1:0] r_hold_slot, n_hold_slot;
    logic [cts_pkg::TAG_W-1:0]  r_hold_tag, n_hold_tag;
    logic                       r_sticky,   n_sticky;

    logic                       r_out_v;
    logic [cts_pkg::ST_W-1:0]   r_out_st,   n_out_st;
    logic [cts_pkg::SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [cts_pkg::TAG_W-1:0]  r_out_tag,  n_out_tag;
    logic                       r_out_err,  n_out_err;
    logic                       r_out_last, n_out_last;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_busy;
    assign out_free      = !r_out_v || m_axis_tready;
    // freeze the token only where it has a result to hand over
    assign go            = out_free || !((hit_or.hit && r_hold_v) || r_end.valid);

    // command capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_in_v <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (end_done) begin
                r_busy <= 1'b0;
            end
            if (accept) begin
                r_in_v <= 1'b1;
            end else if (go) begin
                r_in_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_cmd    <= s_axis_tuser;
            r_in_tag    <= s_axis_tdata[15:0];
            r_in_delay  <= s_axis_tdata[47:16];
            r_in_period <= s_axis_tdata[79:48];
            r_in_idx    <= s_axis_tdata[87:80];
        end
    end

    // ms to ticks by reciprocal multiply, registered in the first cell
    assign prod_delay  = (2*cts_pkg::MS_W)'(r_in_delay) *
                         (2*cts_pkg::MS_W)'(cts_pkg::DIV10_MAGIC);
    assign prod_period = (2*cts_pkg::MS_W)'(r_in_period) *
                         (2*cts_pkg::MS_W)'(cts_pkg::DIV10_MAGIC);

    always_comb begin
        tok_link[0]        = '0;
        tok_link[0].valid  = r_in_v;
        tok_link[0].cmd    = r_in_cmd;
        tok_link[0].tag    = r_in_tag;
        tok_link[0].delay  =
            prod_delay[cts_pkg::DIV10_SHIFT +: cts_pkg::TICK_W];
        tok_link[0].period =
            prod_period[cts_pkg::DIV10_SHIFT +: cts_pkg::TICK_W];
        tok_link[0].idx    = r_in_idx;
        tok_link[0].status = cts_pkg::ST_OK;
    end

    // slot cells
    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        cts_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_go    (go),
            .i_tok   (tok_link[g]),
            .o_tok   (tok_link[g+1]),
            .o_hit   (hits[g])
        );
    end

    // at most one cell holds the token, so the hits merge by or
    always_comb begin
        hit_or = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            hit_or = hit_or | hits[i];
        end
    end

    // token leaving the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end <= '0;
        end else if (go) begin
            r_end <= tok_link[TASK_SLOTS];
        end
    end

    // result forming: a dispatch hit is held back until its last flag is known
    always_comb begin
        out_load    = 1'b0;
        end_done    = 1'b0;
        n_hold_v    = r_hold_v;
        n_hold_slot = r_hold_slot;
        n_hold_tag  = r_hold_tag;
        n_sticky    = r_sticky;
        n_out_st    = cts_pkg::ST_OK;
        n_out_slot  = '0;
        n_out_tag   = '0;
        n_out_last  = 1'b0;
        if (go && hit_or.hit) begin
            if (r_hold_v) begin
                out_load   = 1'b1;
                n_out_slot = r_hold_slot;
                n_out_tag  = r_hold_tag;
            end
            n_hold_v    = 1'b1;
            n_hold_slot = hit_or.slot;
            n_hold_tag  = hit_or.tag;
        end
        if (go && r_end.valid) begin
            out_load   = 1'b1;
            end_done   = 1'b1;
            n_out_last = 1'b1;
            case (r_end.cmd)
                cts_pkg::CMD_TICK: begin
                    n_out_st = cts_pkg::ST_OK;
                end
                cts_pkg::CMD_DISPATCH: begin
                    if (r_hold_v) begin
                        n_out_slot = r_hold_slot;
                        n_out_tag  = r_hold_tag;
                        n_hold_v   = 1'b0;
                    end else begin
                        n_out_st = cts_pkg::ST_NONE_DUE;
                    end
                end
                cts_pkg::CMD_ADD: begin
                    if (r_end.found) begin
                        n_out_slot = r_end.slot;
                    end else begin
                        n_out_st   = cts_pkg::ST_FULL;
                        n_out_slot = FULL_SLOT;
                        n_sticky   = 1'b1;
                    end
                end
                cts_pkg::CMD_DELETE: begin
                    if (r_end.idx >= SLOT_LIMIT) begin
                        n_out_st = cts_pkg::ST_RANGE;
                    end else begin
                        n_out_st   = r_end.status;
                        n_out_slot = r_end.idx[cts_pkg::SLOT_W-1:0];
                    end
                end
                default: begin
                    n_out_st = cts_pkg::ST_OK;
                end
            endcase
        end
        n_out_err = n_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_sticky <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_hold_v <= n_hold_v;
            r_sticky <= n_sticky;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_slot <= n_hold_slot;
        r_hold_tag  <= n_hold_tag;
        if (out_load) begin
            r_out_st   <= n_out_st;
            r_out_slot <= n_out_slot;
            r_out_tag  <= n_out_tag;
            r_out_err  <= n_out_err;
            r_out_last <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_err, r_out_tag, r_out_slot, r_out_st};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== src/cts_cell.sv =====
module cts_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  cts_pkg::t_tok i_tok,
    output cts_pkg::t_tok o_tok,
    output cts_pkg::t_hit o_hit
);

    localparam logic [cts_pkg::SLOT_W-1:0] MY_SLOT = cts_pkg::SLOT_W'(IDX);
    localparam logic [cts_pkg::IDX_W-1:0]  MY_IDX  = cts_pkg::IDX_W'(IDX);

    cts_pkg::t_tok r_tok;

    logic                       r_valid,   n_valid;
    logic [cts_pkg::TAG_W-1:0]  r_tag,     n_tag;
    logic [cts_pkg::TICK_W-1:0] r_delay,   n_delay;
    logic [cts_pkg::TICK_W-1:0] r_period,  n_period;
    logic [cts_pkg::PEND_W-1:0] r_pending, n_pending;

    // slot update for the token sitting in this cell
    always_comb begin
        o_tok     = r_tok;
        o_hit     = '0;
        n_valid   = r_valid;
        n_tag     = r_tag;
        n_delay   = r_delay;
        n_period  = r_period;
        n_pending = r_pending;
        if (r_tok.valid) begin
            case (r_tok.cmd)
                cts_pkg::CMD_TICK: begin
                    if (r_valid) begin
                        if (r_delay == '0) begin
                            if (r_pending != cts_pkg::PEND_MAX) begin
                                n_pending = r_pending + 1'b1;
                            end
                            if (r_period != '0) begin
                                n_delay = r_period;
                            end
                        end else begin
                            n_delay = r_delay - 1'b1;
                        end
                    end
                end
                cts_pkg::CMD_DISPATCH: begin
                    if (r_pending != '0 &&
                        r_tok.cnt < cts_pkg::CNT_W'(cts_pkg::MAX_RESULTS)) begin
                        o_hit.hit  = 1'b1;
                        o_hit.slot = MY_SLOT;
                        o_hit.tag  = r_tag;
                        o_tok.cnt  = r_tok.cnt + 1'b1;
                        n_pending  = r_pending - 1'b1;
                        // one-shot slot is freed after its run
                        if (r_period == '0) begin
                            n_valid   = 1'b0;
                            n_tag     = '0;
                            n_delay   = '0;
                            n_pending = '0;
                        end
                    end
                end
                cts_pkg::CMD_ADD: begin
                    if (!r_valid && !r_tok.found) begin
                        n_valid     = 1'b1;
                        n_tag       = r_tok.tag;
                        n_delay     = r_tok.delay;
                        n_period    = r_tok.period;
                        n_pending   = '0;
                        o_tok.found = 1'b1;
                        o_tok.slot  = MY_SLOT;
                    end
                end
                cts_pkg::CMD_DELETE: begin
                    if (r_tok.idx == MY_IDX) begin
                        o_tok.status = r_valid ? cts_pkg::ST_OK : cts_pkg::ST_EMPTY;
                        n_valid      = 1'b0;
                        n_tag        = '0;
                        n_delay      = '0;
                        n_period     = '0;
                        n_pending    = '0;
                    end
                end
                default: begin
                    o_tok = r_tok;
                end
            endcase
        end
    end

    // token register and slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok     <= '0;
            r_valid   <= 1'b0;
            r_tag     <= '0;
            r_delay   <= '0;
            r_period  <= '0;
            r_pending <= '0;
        end else if (i_go) begin
            r_tok <= i_tok;
            if (r_tok.valid) begin
                r_valid   <= n_valid;
                r_tag     <= n_tag;
                r_delay   <= n_delay;
                r_period  <= n_period;
                r_pending <= n_pending;
            end
        end
    end

endmodule

// ===== src/cts_checker.sv =====
module cts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic r_err_seen;

    // error mark seen on any result so far
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[23]) begin
            r_err_seen <= 1'b1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // one command in flight: no new command right after a transfer
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken while another is in flight");

    // status code is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= cts_pkg::ST_RANGE)
        else $error("undefined status code");

    // error mark never falls once shown
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_err_seen |-> m_axis_tdata[23])
        else $error("error mark cleared without reset");

endmodule

bind cooperative_task_scheduler cts_checker u_cts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
